[rtl/periodic_task_tick_scheduler_assert.svh]
// Assertion macros for the periodic task tick scheduler
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PTTS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PTTS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/ptts_pkg.sv]
// Package: types, codes and constants of the periodic task tick scheduler
`timescale 1ns / 1ps
package ptts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ADD      = 3'd1;
  localparam logic [2:0] CMD_REMOVE   = 3'd2;
  localparam logic [2:0] CMD_RUN      = 3'd3;
  localparam logic [2:0] CMD_SET_TIME = 3'd4;
  localparam logic [2:0] CMD_RD_TIME  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_TIME = 2'd2;

  localparam logic [1:0] PH_MILLIS  = 2'd0;
  localparam logic [1:0] PH_SECONDS = 2'd1;
  localparam logic [1:0] PH_MINUTES = 2'd2;
  localparam logic [1:0] PH_HOURS   = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [15:0] period_in;
    logic [15:0] first_delay;
    logic [7:0]  task_tag_in;
    logic [31:0] time_value;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] ready_slot;
    logic [7:0] task_tag_out;
    logic       last;
    logic [9:0] millis;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
  } result_t;

  typedef struct packed {
    logic        go;
    logic [31:0] dividend;
    logic [9:0]  divisor;
    logic [31:0] magic;
    logic [5:0]  shift;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [9:0]  remainder;
  } div_rsp_t;

  function automatic logic [9:0] time_divisor(logic [1:0] phase);
    logic [9:0] d;
    case (phase)
      PH_MILLIS:  d = 10'd1000;
      PH_SECONDS: d = 10'd60;
      PH_MINUTES: d = 10'd60;
      default:    d = 10'd24;
    endcase
    return d;
  endfunction

  // reciprocal of the divisor, scaled by 2 to the power of time_shift
  function automatic logic [31:0] time_magic(logic [1:0] phase);
    logic [31:0] m;
    case (phase)
      PH_MILLIS:  m = 32'h1062_4DD3;
      PH_SECONDS: m = 32'h8888_8889;
      PH_MINUTES: m = 32'h8888_8889;
      default:    m = 32'hAAAA_AAAB;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] time_shift(logic [1:0] phase);
    logic [5:0] s;
    case (phase)
      PH_MILLIS:  s = 6'd38;
      PH_SECONDS: s = 6'd37;
      PH_MINUTES: s = 6'd37;
      default:    s = 6'd36;
    endcase
    return s;
  endfunction

endpackage

[rtl/ptts_div.sv]
// Reciprocal-multiply divider of a 32-bit count by a small constant divisor
`timescale 1ns / 1ps
module ptts_div
  import ptts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        pending;
  logic        done;
  logic [63:0] prod;
  logic [9:0]  low_q;
  logic [9:0]  divisor_q;
  logic [5:0]  shift_q;
  logic [31:0] quotient;
  logic [9:0]  remainder;
  logic [31:0] quot_next;
  logic [19:0] back;

  assign quot_next = 32'(prod >> shift_q);
  assign back      = quot_next[9:0] * divisor_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      pending <= req.go;
      done    <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod      <= 64'(req.dividend) * 64'(req.magic);
      low_q     <= req.dividend[9:0];
      divisor_q <= req.divisor;
      shift_q   <= req.shift;
    end
    if (pending) begin
      quotient  <= quot_next;
      remainder <= low_q - back[9:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quotient;
  assign rsp.remainder = remainder;

endmodule

[rtl/periodic_task_tick_scheduler.sv]
// Top level: task slot table, command sequencer and time readout
//
//  channel  handshake             payload          accepted when
//  command  start / busy          item   (item_t)   start && !busy at clk edge
//  result   strobe                result (result_t) every clk edge with strobe
//
// Add, remove and set time complete at the accepting edge; busy stays low.
// Tick and run walk the slots one per cycle; run stops after the last pending slot.
// Read time runs four divisions, millis to hours, in turn on the shared multiplier.
// Run results follow at most one per cycle; none-ready comes in the cycle after start.
// Synchronous reset clears slot marks, counter and sequencer; results cannot stall.
`timescale 1ns / 1ps
module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TICK = 4'b0010,
    S_RUN  = 4'b0100,
    S_TIME = 4'b1000
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] idx;
  logic [1:0]        phase;
  logic [SLOTS-1:0]  active;
  logic [SLOTS-1:0]  ready;
  logic [31:0]       ms_count;
  logic [15:0]       slot_period    [SLOTS];
  logic [15:0]       slot_countdown [SLOTS];
  logic [7:0]        slot_tag       [SLOTS];

  logic              accept;
  logic              slot_ok;
  logic [SLOT_W-1:0] add_idx;
  logic              add_ok;
  logic [15:0]       cur_cd;
  logic [15:0]       cur_per;
  logic [15:0]       cd_dec;
  logic              tick_fire;
  logic [SLOTS-1:0]  pend;
  logic [SLOTS-1:0]  higher;
  logic              hit;
  logic              run_last;
  logic              idx_end;
  logic              emit_none;
  logic              emit_run;
  logic              emit_time;
  logic [1:0]        div_phase;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;
  assign slot_ok   = 32'(item.slot) < SLOTS;
  assign add_idx   = SLOT_W'(item.slot);
  assign add_ok    = accept && item.cmd == CMD_ADD && slot_ok && !active[add_idx];
  assign cur_cd    = slot_countdown[idx];
  assign cur_per   = slot_period[idx];
  assign cd_dec    = (cur_cd != 16'd0) ? cur_cd - 16'd1 : 16'd0;
  assign tick_fire = cd_dec == 16'd0;
  assign pend      = active & ready;
  assign higher    = ({SLOTS{1'b1}} << idx) << 1;
  assign hit       = pend[idx];
  assign run_last  = ~|(pend & higher);
  assign idx_end   = idx == SLOT_W'(SLOTS - 1);

  assign emit_none = accept && item.cmd == CMD_RUN && pend == '0;
  assign emit_run  = state == S_RUN && hit;
  assign emit_time = state == S_TIME && div_rsp.done && phase == PH_HOURS;

  assign div_phase        = (state == S_TIME) ? phase + 2'd1 : PH_MILLIS;
  assign div_req.go       = (accept && item.cmd == CMD_RD_TIME) ||
                            (state == S_TIME && div_rsp.done && phase != PH_HOURS);
  assign div_req.dividend = (state == S_TIME) ? div_rsp.quotient : ms_count;
  assign div_req.divisor  = time_divisor(div_phase);
  assign div_req.magic    = time_magic(div_phase);
  assign div_req.shift    = time_shift(div_phase);

  ptts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      phase    <= PH_MILLIS;
      active   <= '0;
      ready    <= '0;
      ms_count <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= emit_none || emit_run || emit_time;
      if (div_req.go) begin
        phase <= div_phase;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.cmd)
              CMD_TICK: begin
                ms_count <= ms_count + 32'd1;
                idx      <= '0;
                state    <= S_TICK;
              end
              CMD_ADD: begin
                if (add_ok) begin
                  active[add_idx] <= 1'b1;
                  ready[add_idx]  <= 1'b0;
                end
              end
              CMD_REMOVE: begin
                if (slot_ok) begin
                  active[add_idx] <= 1'b0;
                end
              end
              CMD_RUN: begin
                idx <= '0;
                if (pend != '0) begin
                  state <= S_RUN;
                end
              end
              CMD_SET_TIME: begin
                ms_count <= item.time_value;
              end
              CMD_RD_TIME: begin
                state <= S_TIME;
              end
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (active[idx] && tick_fire) begin
            ready[idx] <= 1'b1;
          end
          idx <= idx + SLOT_W'(1);
          if (idx_end) begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (hit) begin
            ready[idx] <= 1'b0;
            if (cur_per == 16'd0) begin
              active[idx] <= 1'b0;
            end
          end
          idx <= idx + SLOT_W'(1);
          if (idx_end || (hit && run_last)) begin
            state <= S_IDLE;
          end
        end
        S_TIME: begin
          if (emit_time) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      slot_period[add_idx]    <= item.period_in;
      slot_countdown[add_idx] <= item.first_delay;
      slot_tag[add_idx]       <= item.task_tag_in;
    end
    if (state == S_TICK && active[idx]) begin
      slot_countdown[idx] <= tick_fire ? cur_per : cd_dec;
    end
    if (emit_none) begin
      result <= '{status: ST_NONE, last: 1'b1, default: '0};
    end
    if (emit_run) begin
      result <= '{status: ST_OK, ready_slot: 4'(idx), task_tag_out: slot_tag[idx],
                  last: run_last, default: '0};
    end
    if (state == S_TIME && div_rsp.done) begin
      case (phase)
        PH_MILLIS: begin
          result <= '{status: ST_TIME, last: 1'b1, millis: div_rsp.remainder,
                      default: '0};
        end
        PH_SECONDS: result.seconds <= div_rsp.remainder[5:0];
        PH_MINUTES: result.minutes <= div_rsp.remainder[5:0];
        default:    result.hours   <= div_rsp.remainder[4:0];
      endcase
    end
  end

`include "periodic_task_tick_scheduler_assert.svh"

  `PTTS_ASSERT_NOW(a_dispatch_clears_ready, strobe && result.status == ST_OK,
    !ready[SLOT_W'(result.ready_slot)], "dispatched slot still marked ready")
  `PTTS_ASSERT_NOW(a_time_readout_single, strobe && result.status == ST_TIME,
    result.last && result.hours < 5'd24, "time readout not final or hours out of range")
  `PTTS_ASSERT_NOW(a_none_ready_direct, strobe && result.status == ST_NONE,
    result.last && $past(state == S_IDLE), "none-ready result not issued from idle")
  `PTTS_ASSERT_NEXT(a_tick_walks, accept && item.cmd == CMD_TICK,
    state == S_TICK && idx == '0, "tick did not start the slot walk")

endmodule

[verif/ptts_checker.sv]
// Checker for the periodic task tick scheduler: predicts each transaction and compares results
`timescale 1ns / 1ps
module ptts_checker
  import ptts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    strobe,
  input  result_t result,
  output int      failures,
  output int      outstanding
);

  logic        slot_on     [SLOTS];
  logic        slot_due    [SLOTS];
  logic [15:0] slot_reload [SLOTS];
  logic [15:0] slot_count  [SLOTS];
  logic [7:0]  slot_label  [SLOTS];
  logic [31:0] clock_ms;
  result_t     awaited_replies [$];
  result_t     oldest_reply;

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i]     = 1'b0;
      slot_due[i]    = 1'b0;
      slot_reload[i] = '0;
      slot_count[i]  = '0;
      slot_label[i]  = '0;
    end
    clock_ms = '0;
  endtask

  task automatic step_scheduler(item_t cmd_item);
    result_t reply;
    int      final_slot;
    reply      = '0;
    final_slot = -1;
    case (cmd_item.cmd)
      CMD_TICK: begin
        clock_ms = clock_ms + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i]) begin
            if (slot_count[i] != 16'd0) slot_count[i] = slot_count[i] - 16'd1;
            if (slot_count[i] == 16'd0) begin
              slot_due[i]   = 1'b1;
              slot_count[i] = slot_reload[i];
            end
          end
        end
      end
      CMD_ADD: begin
        if (!slot_on[cmd_item.slot]) begin
          slot_on[cmd_item.slot]     = 1'b1;
          slot_reload[cmd_item.slot] = cmd_item.period_in;
          slot_count[cmd_item.slot]  = cmd_item.first_delay;
          slot_label[cmd_item.slot]  = cmd_item.task_tag_in;
          slot_due[cmd_item.slot]    = 1'b0;
        end
      end
      CMD_REMOVE: slot_on[cmd_item.slot] = 1'b0;
      CMD_RUN: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i] && slot_due[i]) final_slot = i;
        end
        if (final_slot < 0) begin
          reply.status = ST_NONE;
          reply.last   = 1'b1;
          awaited_replies.push_back(reply);
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_on[i] && slot_due[i]) begin
              reply              = '0;
              reply.status       = ST_OK;
              reply.ready_slot   = 4'(i);
              reply.task_tag_out = slot_label[i];
              reply.last         = (i == final_slot);
              awaited_replies.push_back(reply);
              slot_due[i] = 1'b0;
              if (slot_reload[i] == 16'd0) slot_on[i] = 1'b0;
            end
          end
        end
      end
      CMD_SET_TIME: clock_ms = cmd_item.time_value;
      CMD_RD_TIME: begin
        reply.status  = ST_TIME;
        reply.last    = 1'b1;
        reply.millis  = 10'(clock_ms % 32'd1000);
        reply.seconds = 6'((clock_ms / 32'd1000) % 32'd60);
        reply.minutes = 6'((clock_ms / 32'd60000) % 32'd60);
        reply.hours   = 5'((clock_ms / 32'd3600000) % 32'd24);
        awaited_replies.push_back(reply);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      awaited_replies.delete();
    end else begin
      if (strobe) begin
        if (awaited_replies.size() == 0) begin
          $error("result with no transaction awaiting it: status %0d slot %0d",
                 result.status, result.ready_slot);
          failures++;
        end else begin
          oldest_reply = awaited_replies.pop_front();
          check_field("status", 32'(oldest_reply.status), 32'(result.status));
          check_field("ready_slot", 32'(oldest_reply.ready_slot), 32'(result.ready_slot));
          check_field("task_tag_out", 32'(oldest_reply.task_tag_out),
                      32'(result.task_tag_out));
          check_field("last", 32'(oldest_reply.last), 32'(result.last));
          check_field("millis", 32'(oldest_reply.millis), 32'(result.millis));
          check_field("seconds", 32'(oldest_reply.seconds), 32'(result.seconds));
          check_field("minutes", 32'(oldest_reply.minutes), 32'(result.minutes));
          check_field("hours", 32'(oldest_reply.hours), 32'(result.hours));
        end
      end
      if (start && !busy) step_scheduler(item);
    end
    outstanding <= awaited_replies.size();
  end

endmodule

[verif/testbench.sv]
// Testbench top: drives scheduler commands, watches for stalls and reports the verdict
`timescale 1ns / 1ps
module testbench;
  import ptts_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO  = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 200;
  localparam int         RANDOM_ITEMS  = 85;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  logic    strobe;
  item_t   item;
  result_t result;
  int      failures;
  int      outstanding;
  int      quiet_cycles;
  int      gap_pct;
  int      sent;

  periodic_task_tick_scheduler uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  ptts_checker reply_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .strobe      (strobe),
    .result      (result),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_item(logic [2:0] cmd, logic [3:0] slot, logic [15:0] per,
                                      logic [15:0] dly, logic [7:0] tag, logic [31:0] tv);
    item_t it;
    it.cmd         = cmd;
    it.slot        = slot;
    it.period_in   = per;
    it.first_delay = dly;
    it.task_tag_in = tag;
    it.time_value  = tv;
    return it;
  endfunction

  function automatic logic [15:0] pick_span();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(0, 4));
    if (r < 90) return 16'($urandom_range(0, 20));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it.slot        = 4'($urandom_range(15));
    it.period_in   = pick_span();
    it.first_delay = pick_span();
    it.task_tag_in = 8'($urandom_range(255));
    it.time_value  = ($urandom_range(99) < 80) ? 32'($urandom)
                                               : 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    pick = $urandom_range(99);
    if (pick < 38)      it.cmd = CMD_TICK;
    else if (pick < 58) it.cmd = CMD_ADD;
    else if (pick < 66) it.cmd = CMD_REMOVE;
    else if (pick < 84) it.cmd = CMD_RUN;
    else if (pick < 89) it.cmd = CMD_SET_TIME;
    else if (pick < 96) it.cmd = CMD_RD_TIME;
    else                it.cmd = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
    return it;
  endfunction

  task automatic issue(item_t it);
    if ($urandom_range(99) < gap_pct) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        start <= 1'b0;
        item  <= random_item();
      end
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.cmd <= CMD_RD_TIME) sent++;
  endtask

  task automatic flood_slots();
    for (int s = 0; s < SLOTS; s++) begin
      issue(make_item(CMD_ADD, 4'(s), 16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)),
                      8'($urandom_range(255)), 32'($urandom)));
    end
    repeat (3) issue(make_item(CMD_TICK, '0, '0, '0, '0, '0));
    issue(make_item(CMD_RUN, '0, '0, '0, '0, '0));
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    item    = '0;
    gap_pct = 0;
    sent    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(make_item(CMD_RD_TIME, '0, '0, '0, '0, '0));
    issue(make_item(CMD_RUN, '0, '0, '0, '0, '0));
    issue(make_item(CMD_ADD, 4'd0, 16'd0, 16'd0, 8'hFF, '0));
    issue(make_item(CMD_ADD, 4'd15, 16'hFFFF, 16'hFFFF, 8'h00, 32'hFFFF_FFFF));
    issue(make_item(CMD_ADD, 4'd0, 16'd3, 16'd3, 8'h5A, '0));
    issue(make_item(CMD_ADD, 4'd5, 16'd1, 16'd2, 8'hA5, '0));
    issue(make_item(CMD_TICK, '0, '0, '0, '0, '0));
    issue(make_item(CMD_TICK, '0, '0, '0, '0, '0));
    issue(make_item(CMD_RUN, '0, '0, '0, '0, '0));
    issue(make_item(CMD_RUN, '0, '0, '0, '0, '0));
    issue(make_item(CMD_TICK, '0, '0, '0, '0, '0));
    issue(make_item(CMD_REMOVE, 4'd7, '0, '0, '0, '0));
    issue(make_item(CMD_REMOVE, 4'd15, '0, '0, '0, '0));
    issue(make_item(CMD_SPARE_LO, 4'd3, 16'd1, 16'd1, 8'h11, 32'd5));
    issue(make_item(CMD_SPARE_HI, 4'd3, 16'd1, 16'd1, 8'h11, 32'd5));
    issue(make_item(CMD_SET_TIME, '0, '0, '0, '0, 32'hFFFF_FFFF));
    issue(make_item(CMD_RD_TIME, '0, '0, '0, '0, '0));
    issue(make_item(CMD_TICK, '0, '0, '0, '0, '0));
    issue(make_item(CMD_RD_TIME, '0, '0, '0, '0, '0));
    issue(make_item(CMD_SET_TIME, '0, '0, '0, '0, 32'd86_399_999));
    issue(make_item(CMD_RD_TIME, '0, '0, '0, '0, '0));
    issue(make_item(CMD_SET_TIME, '0, '0, '0, '0, 32'd86_400_000));
    issue(make_item(CMD_RD_TIME, '0, '0, '0, '0, '0));
    issue(make_item(CMD_RUN, '0, '0, '0, '0, '0));
    issue(make_item(CMD_REMOVE, 4'd5, '0, '0, '0, '0));

    sent = 0;
    flood_slots();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: gap_pct = 0;
        1: gap_pct = 45;
        2: gap_pct = 0;
        default: gap_pct = 14;
      endcase
      while (sent < RANDOM_ITEMS * (phase + 1) / 4) begin
        if ($urandom_range(99) < 4) flood_slots();
        else issue(random_item());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
